@@ rtl/core/pbtt_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the tally table.
package pbtt_pkg;

	localparam int TABLE_SLOTS = 32;
	localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

	localparam int ID_W        = 22;
	localparam int BYTES_W     = 40;
	localparam int BPE_W       = 17;
	localparam int THR_W       = 20;
	localparam int KIB_SHIFT   = 10;
	localparam int CHG_W       = BYTES_W - KIB_SHIFT;
	localparam int ENTRY_W     = ID_W + BYTES_W;

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_EVENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALERT_THRESHOLD = 2'd1;

	localparam logic [BPE_W-1:0] BPE_RESET = 17'd4096;
	localparam logic [THR_W-1:0] THR_RESET = 20'd1000;

	localparam logic CMD_WRITE    = 1'b0;
	localparam logic CMD_TICK     = 1'b1;
	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_ENTRY   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLAIM,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_TICK_DIFF,
		ST_TICK_SUM,
		ST_DUMP_RD,
		ST_DUMP_OUT
	} state_t;

	typedef struct packed {
		logic load_event;
		logic clr_idx;
		logic inc_idx;
		logic wr_hit;
		logic wr_claim;
		logic calc_diff;
		logic emit_summary;
		logic emit_entry;
		logic clear_used;
	} ctrl_cmd_t;

	typedef struct packed {
		logic id_zero;
		logic used_zero;
		logic used_full;
		logic idx_last;
		logic id_hit;
	} dp_status_t;

endpackage

@@ rtl/core/pbtt_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module pbtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AddrW-1:0] wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AddrW-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ rtl/core/pbtt_ctrl.sv @@
// Controller state machine: sequences slot scans, claims and the tick dump.
module pbtt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                cmd,
	input  pbtt_pkg::dp_status_t status,
	output logic                busy,
	output pbtt_pkg::ctrl_cmd_t  ctl
);

	import pbtt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (cmd == CMD_TICK) begin
						state_d = ST_TICK_DIFF;
					end else if (!status.id_zero) begin
						ctl.load_event = 1'b1;
						ctl.clr_idx    = 1'b1;
						if (status.used_zero) begin
							state_d = ST_CLAIM;
						end else if (!status.used_full) begin
							state_d = ST_SCAN_RD;
						end
					end
				end
			end
			ST_CLAIM: begin
				ctl.wr_claim = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				priority if (status.id_hit) begin
					ctl.wr_hit = 1'b1;
					state_d    = ST_IDLE;
				end else if (status.idx_last) begin
					ctl.wr_claim = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					ctl.inc_idx = 1'b1;
					state_d     = ST_SCAN_RD;
				end
			end
			ST_TICK_DIFF: begin
				ctl.calc_diff = 1'b1;
				state_d       = ST_TICK_SUM;
			end
			ST_TICK_SUM: begin
				ctl.emit_summary = 1'b1;
				ctl.clr_idx      = 1'b1;
				state_d          = status.used_zero ? ST_IDLE : ST_DUMP_RD;
			end
			ST_DUMP_RD: begin
				state_d = ST_DUMP_OUT;
			end
			ST_DUMP_OUT: begin
				ctl.emit_entry = 1'b1;
				if (status.idx_last) begin
					ctl.clear_used = 1'b1;
					state_d        = ST_IDLE;
				end else begin
					ctl.inc_idx = 1'b1;
					state_d     = ST_DUMP_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/pbtt_dpath.sv @@
// Datapath: configuration, totals, slot RAM, scan index and result registers.
module pbtt_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [pbtt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbtt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [pbtt_pkg::ID_W-1:0]       owner_id,
	input  pbtt_pkg::ctrl_cmd_t             ctl,
	output pbtt_pkg::dp_status_t            status,
	output logic                          strobe,
	output logic                          kind,
	output logic [pbtt_pkg::ID_W-1:0]       report_id,
	output logic [pbtt_pkg::BYTES_W-1:0]    byte_count,
	output logic [pbtt_pkg::CHG_W-1:0]      change_kib,
	output logic                          alert,
	output logic                          last
);

	import pbtt_pkg::*;

	function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] a,
	                                               input logic [BPE_W-1:0] b);
		logic [BYTES_W:0] s;
		s = {1'b0, a} + (BYTES_W+1)'(b);
		return s[BYTES_W] ? '1 : s[BYTES_W-1:0];
	endfunction

	logic [BPE_W-1:0]   bpe_q;
	logic [THR_W-1:0]   thr_q;
	logic [BYTES_W-1:0] total_q;
	logic [BYTES_W-1:0] prev_q;
	logic [CNT_W-1:0]   used_q;
	logic [IDX_W-1:0]   idx_q;
	logic [ID_W-1:0]    id_q;
	logic [CHG_W-1:0]   chg_s1;

	logic               strobe_q;
	logic               kind_q;
	logic [ID_W-1:0]    report_id_q;
	logic [BYTES_W-1:0] byte_count_q;
	logic [CHG_W-1:0]   change_kib_q;
	logic               alert_q;
	logic               last_q;

	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic [ENTRY_W-1:0] rd_data;
	logic [ID_W-1:0]    rd_id;
	logic [BYTES_W-1:0] rd_bytes;
	logic [BYTES_W-1:0] diff;

	assign rd_id    = rd_data[ENTRY_W-1:BYTES_W];
	assign rd_bytes = rd_data[BYTES_W-1:0];

	assign status.id_zero   = (owner_id == '0);
	assign status.used_zero = (used_q == '0);
	assign status.used_full = (used_q == CNT_W'(TABLE_SLOTS));
	assign status.idx_last  = ((CNT_W'(idx_q) + CNT_W'(1)) == used_q);
	assign status.id_hit    = (rd_id == id_q);

	// Claim writes at the fill point, a hit writes back where the scan stopped.
	assign wr_en   = ctl.wr_hit | ctl.wr_claim;
	assign wr_addr = ctl.wr_hit ? idx_q : used_q[IDX_W-1:0];
	assign wr_data = ctl.wr_hit ? {id_q, sat_add(rd_bytes, bpe_q)}
	                            : {id_q, BYTES_W'(bpe_q)};

	assign diff = (total_q >= prev_q) ? (total_q - prev_q) : (prev_q - total_q);

	pbtt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_SLOTS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpe_q    <= BPE_RESET;
			thr_q    <= THR_RESET;
			total_q  <= '0;
			prev_q   <= '0;
			used_q   <= '0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_BYTES_PER_EVENT: bpe_q <= cfg_data[BPE_W-1:0];
					CFG_ALERT_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			if (ctl.load_event) begin
				total_q <= sat_add(total_q, bpe_q);
			end
			if (ctl.emit_summary) begin
				prev_q  <= total_q;
				total_q <= '0;
			end
			priority if (ctl.clear_used) begin
				used_q <= '0;
			end else if (ctl.wr_claim) begin
				used_q <= used_q + CNT_W'(1);
			end
			priority if (ctl.clr_idx) begin
				idx_q <= '0;
			end else if (ctl.inc_idx) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			strobe_q <= ctl.emit_summary | ctl.emit_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_event) begin
			id_q <= owner_id;
		end
		if (ctl.calc_diff) begin
			chg_s1 <= diff[BYTES_W-1:KIB_SHIFT];
		end
		if (ctl.emit_summary) begin
			kind_q       <= KIND_SUMMARY;
			report_id_q  <= '0;
			byte_count_q <= total_q;
			change_kib_q <= chg_s1;
			alert_q      <= (chg_s1 > CHG_W'(thr_q));
			last_q       <= status.used_zero;
		end else if (ctl.emit_entry) begin
			kind_q       <= KIND_ENTRY;
			report_id_q  <= rd_id;
			byte_count_q <= rd_bytes;
			change_kib_q <= '0;
			alert_q      <= 1'b0;
			last_q       <= status.idx_last;
		end
	end

	assign strobe     = strobe_q;
	assign kind       = kind_q;
	assign report_id  = report_id_q;
	assign byte_count = byte_count_q;
	assign change_kib = change_kib_q;
	assign alert      = alert_q;
	assign last       = last_q;

`ifndef SYNTH
	a_claim_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_claim |-> !status.used_full)
		else $error("slot claimed on a full table");
	a_claim_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.wr_claim && !ctl.clear_used) |=> (used_q == $past(used_q) + CNT_W'(1)))
		else $error("fill count did not advance on claim");
	a_summary_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit_summary |=> (total_q == '0 && prev_q == $past(total_q)))
		else $error("interval total not rolled over on summary");
`endif

endmodule

@@ rtl/core/per_id_byte_tally_table.sv @@
// Top level of the per-ID byte tally table: controller plus datapath.
//
// A word is taken when start is high and busy is low. cmd 0 is a write event for
// owner_id: it adds bytes_per_event to the saturating interval total and to the slot
// of that ID, claiming the next free slot for a new ID; ID 0 is dropped and a full
// table only counts the total. cmd 1 is a tick: one summary word, then one word per
// used slot in slot order, the final one flagged by last; the table and the total
// then clear. Results come out on strobe for exactly one cycle each and cannot be
// held off, so the receiver must take every strobed word. A dropped ID or a full
// table is handled in idle, a first claim into an empty table in the claim state;
// other events scan the used slots from slot 0, write back on a hit or claim the fill
// point after the last slot. A tick runs the diff and sum states, then dumps the entries;
// busy stays high throughout. The scan rate is set by the slot RAM, which
// has a single read port with a registered read, so each slot visit passes a read
// state and a compare state. No clearing pass runs after reset: a fill count marks
// the used slots. Configuration writes are always taken (cfg_ready stays high).
module per_id_byte_tally_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic [pbtt_pkg::ID_W-1:0]       owner_id,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pbtt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbtt_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                          strobe,
	output logic                          kind,
	output logic [pbtt_pkg::ID_W-1:0]       report_id,
	output logic [pbtt_pkg::BYTES_W-1:0]    byte_count,
	output logic [pbtt_pkg::CHG_W-1:0]      change_kib,
	output logic                          alert,
	output logic                          last
);

	import pbtt_pkg::*;

	ctrl_cmd_t  ctl;
	dp_status_t status;

	// Registers are written straight from the port; accept every word.
	assign cfg_ready = 1'b1;

	// Sequence the scan, claim and dump steps.
	pbtt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.status (status),
		.busy   (busy),
		.ctl    (ctl)
	);

	// Hold the slots, totals and the result word.
	pbtt_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.owner_id   (owner_id),
		.ctl        (ctl),
		.status     (status),
		.strobe     (strobe),
		.kind       (kind),
		.report_id  (report_id),
		.byte_count (byte_count),
		.change_kib (change_kib),
		.alert      (alert),
		.last       (last)
	);

`ifndef SYNTH
	// Result strobes never come back to back.
	a_strobe_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe)
		else $error("result strobe on consecutive cycles");
`endif

endmodule
